@@ rtl/gdtc_pkg.sv @@
package gdtc_pkg;

    // Field widths of the stream words.
    localparam int VALUE_W     = 12;
    localparam int GAP_W       = 13;
    localparam int PAIRS_OUT_W = 12;
    localparam int TOTAL_W     = 34;

    // Packed stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    // Width of the signed threshold arithmetic (value + gap against the range).
    localparam int THR_W = 18;

    // Defaults for the top-level parameters.
    localparam int DEF_VALUE_RANGE = 4096;
    localparam int DEF_MAX_ITEMS   = 4096;

    // One finished result word.
    typedef struct packed {
        logic [PAIRS_OUT_W-1:0] pairs_here;
        logic [TOTAL_W-1:0]     triple_total;
        logic                   overflow;
        logic                   last;
    } res_t;

    // Memory port strobes from the sequencer.
    typedef struct packed {
        logic re;
        logic we;
    } mem_ctl_t;

endpackage

@@ rtl/gdtc_tree_mem.sv @@
module gdtc_tree_mem #(
    parameter int DEPTH  = gdtc_pkg::DEF_VALUE_RANGE,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 36
) (
    input  logic                  aclk,
    input  gdtc_pkg::mem_ctl_t    ctl,
    input  logic [ADDR_W-1:0]     raddr,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [DATA_W-1:0]     wdata,
    output logic [DATA_W-1:0]     rdata
);

    // Both trees share one word: count node in the low bits, pair node above.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gdtc_ctrl.sv @@
module gdtc_ctrl #(
    parameter int VALUE_RANGE = gdtc_pkg::DEF_VALUE_RANGE,
    parameter int MAX_ITEMS   = gdtc_pkg::DEF_MAX_ITEMS,
    parameter int IDX_W       = 12,
    parameter int POS_W       = 13,
    parameter int CNT_W       = 13,
    parameter int PAIR_W      = 23
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Incoming item.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gdtc_pkg::VALUE_W-1:0]       in_value,
    input  logic                               in_last,
    input  logic signed [gdtc_pkg::GAP_W-1:0]  gap,
    // Result toward the output register.
    input  logic                               out_free,
    output logic                               res_valid,
    output gdtc_pkg::res_t                     res,
    // Tree memory port.
    output gdtc_pkg::mem_ctl_t                 mem_ctl,
    output logic [IDX_W-1:0]                   mem_raddr,
    output logic [IDX_W-1:0]                   mem_waddr,
    output logic [CNT_W+PAIR_W-1:0]            mem_wdata,
    input  logic [CNT_W+PAIR_W-1:0]            mem_rdata
);

    localparam logic signed [gdtc_pkg::THR_W-1:0] VR_S    = gdtc_pkg::THR_W'(VALUE_RANGE);
    localparam logic signed [gdtc_pkg::THR_W-1:0] VR_M1_S = gdtc_pkg::THR_W'(VALUE_RANGE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_UPD_RD,
        S_UPD_WR,
        S_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    logic [POS_W-1:0]                    k_reg, k_next;
    logic [POS_W-1:0]                    p_reg, p_next;
    logic [CNT_W-1:0]                    cnt_acc_reg, cnt_acc_next;
    logic [PAIR_W-1:0]                   pair_acc_reg, pair_acc_next;
    logic                                pend_reg, pend_next;
    logic [gdtc_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [CNT_W-1:0]                    items_reg, items_next;
    logic                                last_reg, last_next;
    logic                                ovf_reg, ovf_next;
    logic [IDX_W-1:0]                    clr_reg, clr_next;

    logic [gdtc_pkg::VALUE_W-1:0]        v_sat;
    logic signed [gdtc_pkg::THR_W-1:0]   thr;
    logic [POS_W-1:0]                    q_pos;
    logic [POS_W-1:0]                    p_pos;
    logic [POS_W-1:0]                    p_low;
    logic [POS_W:0]                      p_sum;
    logic [CNT_W-1:0]                    rd_cnt;
    logic [PAIR_W-1:0]                   rd_pair;

    assign rd_cnt  = mem_rdata[CNT_W-1:0];
    assign rd_pair = mem_rdata[CNT_W +: PAIR_W];

    // Saturate the value, then map the threshold onto a Fenwick prefix length.
    // Values are stored mirrored (position VALUE_RANGE - value), so a suffix
    // over values becomes a prefix over positions.
    always_comb begin
        if (17'(in_value) > 17'(VALUE_RANGE - 1)) begin
            v_sat = gdtc_pkg::VALUE_W'(VALUE_RANGE - 1);
        end else begin
            v_sat = in_value;
        end
        thr = $signed({{(gdtc_pkg::THR_W - gdtc_pkg::VALUE_W){1'b0}}, v_sat})
            + gdtc_pkg::THR_W'(gap);
        if (thr <= 0) begin
            q_pos = POS_W'(VALUE_RANGE);
        end else if (thr > VR_M1_S) begin
            q_pos = '0;
        end else begin
            q_pos = POS_W'(VR_S - thr);
        end
        p_pos = POS_W'(VALUE_RANGE) - POS_W'(v_sat);
    end

    // Next update position: add the lowest set bit.
    assign p_low = p_reg & (~p_reg + 1'b1);
    assign p_sum = {1'b0, p_reg} + {1'b0, p_low};

    // Result word as shown to the output register.
    always_comb begin
        res.pairs_here   = gdtc_pkg::PAIRS_OUT_W'(cnt_acc_reg);
        res.triple_total = total_reg;
        res.overflow     = ovf_reg;
        res.last         = last_reg;
    end

    // Sequencer: clear sweep, prefix query, node updates, hand-off.
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        cnt_acc_next  = cnt_acc_reg;
        pair_acc_next = pair_acc_reg;
        pend_next     = 1'b0;
        total_next    = total_reg;
        items_next    = items_reg;
        last_next     = last_reg;
        ovf_next      = ovf_reg;
        clr_next      = clr_reg;
        mem_ctl       = '0;
        mem_raddr     = '0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        res_valid     = 1'b0;
        in_ready      = (state_reg == S_IDLE);

        // Query reads return in the cycle after issue and are summed here.
        if (pend_reg) begin
            cnt_acc_next  = cnt_acc_reg + rd_cnt;
            pair_acc_next = pair_acc_reg + rd_pair;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_ctl.we = 1'b1;
                mem_waddr  = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(VALUE_RANGE - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    last_next     = in_last;
                    cnt_acc_next  = '0;
                    pair_acc_next = '0;
                    if (items_reg >= CNT_W'(MAX_ITEMS)) begin
                        ovf_next   = 1'b1;
                        state_next = S_FINISH;
                    end else begin
                        ovf_next   = 1'b0;
                        k_next     = q_pos;
                        p_next     = p_pos;
                        state_next = S_QUERY;
                    end
                end
            end
            S_QUERY: begin
                if (k_reg != '0) begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = IDX_W'(k_reg - 1'b1);
                    k_next     = k_reg & (k_reg - 1'b1);
                    pend_next  = 1'b1;
                end else begin
                    state_next = S_UPD_RD;
                end
            end
            S_UPD_RD: begin
                mem_ctl.re = 1'b1;
                mem_raddr  = IDX_W'(p_reg - 1'b1);
                total_next = total_reg + gdtc_pkg::TOTAL_W'(pair_acc_reg);
                items_next = items_reg + 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR: begin
                // Write this node back and fetch the next one in the same cycle.
                mem_ctl.we = 1'b1;
                mem_waddr  = IDX_W'(p_reg - 1'b1);
                mem_wdata  = {rd_pair + PAIR_W'(cnt_acc_reg), rd_cnt + 1'b1};
                if (p_sum <= (POS_W + 1)'(VALUE_RANGE)) begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = IDX_W'(p_sum - 1'b1);
                    p_next     = POS_W'(p_sum);
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    if (last_reg) begin
                        total_next = '0;
                        items_next = '0;
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            total_reg <= '0;
            items_reg <= '0;
            last_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            total_reg <= total_next;
            items_reg <= items_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
        end
        k_reg        <= k_next;
        p_reg        <= p_next;
        cnt_acc_reg  <= cnt_acc_next;
        pair_acc_reg <= pair_acc_next;
    end

    // A node write never collides with the read issued alongside it.
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.we && mem_ctl.re) |-> (mem_waddr != mem_raddr))
        else $error("tree memory read and write hit the same node");

    // A result is only handed over when the output register can take it.
    a_res_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result issued into a full output register");

    // The item counter never passes the item limit.
    a_items_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        items_reg <= CNT_W'(MAX_ITEMS))
        else $error("item counter beyond limit");

    // The end of a sequence starts a clear sweep with the counters at zero.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.last) |=> (state_reg == S_CLEAR && items_reg == '0
            && total_reg == '0 && clr_reg == '0))
        else $error("sequence end did not restart the clear sweep");

    // No item is taken while the trees are being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item accepted during clear sweep");

endmodule

@@ rtl/gap_decreasing_triple_counter_unit.sv @@
// Gap decreasing triple counter.
// The s_ channel takes one word per sequence element (s_tdata value, s_tlast
// marks the last element). For every word the m_ channel returns one word: the
// number of earlier elements with a value of at least value + gap, the running
// count of triples falling by at least gap at each step, an overflow flag and a
// copy of tlast. The gap register is written through cfg_valid/cfg_data; the
// user must do so only while idle, as the block itself does not enforce it.
// Both value-indexed counts live as Fenwick trees in one memory word per
// position; an element takes one read per prefix level, then one
// read-modify-write per update level on a single read and a single write port
// (at most 12 query and 13 update levels with a 4096-entry range). An element
// past the item limit skips both and goes straight to its result. The next
// element is taken only after the previous result enters the output register.
// After reset, and after every word marked last, the memory is swept to zero
// one entry per cycle; s_tready stays low meanwhile.
// When the receiver stalls, the finished word waits in the output register and
// one more element can be taken and computed; its result holds until then.
module gap_decreasing_triple_counter_unit #(
    parameter int VALUE_RANGE = gdtc_pkg::DEF_VALUE_RANGE,
    parameter int MAX_ITEMS   = gdtc_pkg::DEF_MAX_ITEMS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Gap register write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gdtc_pkg::GAP_W-1:0]           cfg_data,
    // Element stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gdtc_pkg::S_TDATA_W-1:0]       s_tdata,  // [11:0] value
    input  logic                                 s_tlast,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gdtc_pkg::M_TDATA_W-1:0]       m_tdata,  // [11:0] pairs_here, [45:12] triple_total
    output logic [0:0]                           m_tuser,  // [0] overflow
    output logic                                 m_tlast
);

    localparam int IDX_W = $clog2(VALUE_RANGE);
    localparam int POS_W = $clog2(VALUE_RANGE + 1);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam longint PAIR_MAX = longint'(MAX_ITEMS) * longint'(MAX_ITEMS - 1) / 2;
    localparam int PAIR_W = $clog2(PAIR_MAX + 1);
    localparam int WORD_W = CNT_W + PAIR_W;

    logic signed [gdtc_pkg::GAP_W-1:0] gap_reg;
    logic                              out_valid_reg;
    gdtc_pkg::res_t                    out_res_reg;
    logic                              out_free;
    logic                              res_valid;
    gdtc_pkg::res_t                    res;
    gdtc_pkg::mem_ctl_t                mem_ctl;
    logic [IDX_W-1:0]                  mem_raddr;
    logic [IDX_W-1:0]                  mem_waddr;
    logic [WORD_W-1:0]                 mem_wdata;
    logic [WORD_W-1:0]                 mem_rdata;

    // Gap register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            gap_reg <= $signed(cfg_data);
        end
    end

    // Output register between the sequencer and the receiver.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.triple_total, out_res_reg.pairs_here};
    assign m_tuser  = out_res_reg.overflow;
    assign m_tlast  = out_res_reg.last;

    gdtc_ctrl #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS),
        .IDX_W       (IDX_W),
        .POS_W       (POS_W),
        .CNT_W       (CNT_W),
        .PAIR_W      (PAIR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[gdtc_pkg::VALUE_W-1:0]),
        .in_last   (s_tlast),
        .gap       (gap_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .mem_raddr (mem_raddr),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    gdtc_tree_mem #(
        .DEPTH  (VALUE_RANGE),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_tree_mem (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int     RANGE        = gdtc_pkg::DEF_VALUE_RANGE;
    localparam int     ITEM_LIMIT   = gdtc_pkg::DEF_MAX_ITEMS;
    localparam int     LATENCY      = 40;
    localparam int     RANDOM_ITEMS = 1240;
    localparam int     HOLD_CYCLES  = 300;
    localparam longint CYCLE_LIMIT  = 4000000;

    // How the values of one random sequence are spread.
    typedef enum int {
        SPREAD_UNIFORM,
        SPREAD_WINDOW,
        SPREAD_FALLING,
        SPREAD_EDGES
    } spread_t;

    typedef struct packed {
        logic [gdtc_pkg::VALUE_W-1:0] value;
        logic                         last;
    } elem_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gdtc_pkg::GAP_W-1:0]     cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [gdtc_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // [11:0] value
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [gdtc_pkg::M_TDATA_W-1:0] m_tdata;          // [11:0] pairs_here, [45:12] triple_total
    logic [0:0]                     m_tuser;          // [0] overflow
    logic                           m_tlast;

    gap_decreasing_triple_counter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Predicted state of the block: per-value counts, per-value pair sums, totals.
    int unsigned                       seen_at_value [RANGE];
    longint unsigned                   pairs_at_value [RANGE];
    logic [gdtc_pkg::TOTAL_W-1:0]      triples_so_far = '0;
    int unsigned                       seq_length     = 0;
    logic signed [gdtc_pkg::GAP_W-1:0] gap_setting    = '0;

    elem_t           elements_queued[$];
    gdtc_pkg::res_t  results_due[$];
    elem_t           offered;
    int              idle_mode      = 1;
    int unsigned     send_wait      = 0;
    int unsigned     rx_wait        = 0;
    int unsigned     hold_left      = 0;
    int unsigned     hold_requests  = 0;
    int unsigned     hold_served    = 0;
    int unsigned     queued_count   = 0;
    int unsigned     accepted_count = 0;
    int unsigned     results_seen   = 0;
    int unsigned     overflow_seen  = 0;
    int unsigned     sequences      = 0;
    int unsigned     gaps_written   = 0;
    int unsigned     mismatches     = 0;
    longint unsigned cycle_count    = 0;
    logic [gdtc_pkg::TOTAL_W-1:0] top_total = '0;
    bit              seq_open       = 1'b0;

    // Works out the result word for one accepted element and updates the state.
    function automatic gdtc_pkg::res_t tally_element(input elem_t e);
        gdtc_pkg::res_t  r;
        int              thr;
        longint unsigned older;
        longint unsigned chains;
        r = '0;
        r.last = e.last;
        if (seq_length >= ITEM_LIMIT) begin
            r.overflow = 1'b1;
        end else begin
            thr = int'(e.value) + int'(gap_setting);
            if (thr < 0) begin
                thr = 0;
            end
            older = 0;
            chains = 0;
            for (int v = thr; v < RANGE; v++) begin
                older += seen_at_value[v];
                chains += pairs_at_value[v];
            end
            triples_so_far = triples_so_far + chains[gdtc_pkg::TOTAL_W-1:0];
            seen_at_value[e.value]++;
            pairs_at_value[e.value] += older;
            seq_length++;
            r.pairs_here = older[gdtc_pkg::PAIRS_OUT_W-1:0];
        end
        r.triple_total = triples_so_far;
        // A word marked last ends the sequence and empties both stores.
        if (e.last) begin
            for (int v = 0; v < RANGE; v++) begin
                seen_at_value[v] = 0;
                pairs_at_value[v] = 0;
            end
            triples_so_far = '0;
            seq_length = 0;
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int draw_idle();
        int r;
        if (idle_mode == 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input gdtc_pkg::res_t want,
                                 input gdtc_pkg::res_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at result %0d: expected pairs=%0d total=%0d ovf=%0b last=%0b",
                     what, results_seen, want.pairs_here, want.triple_total,
                     want.overflow, want.last);
            $display("    got pairs=%0d total=%0d ovf=%0b last=%0b",
                     got.pairs_here, got.triple_total, got.overflow, got.last);
        end
    endtask

    // Sender: offers queued words and predicts each one at its acceptance.
    always @(posedge aclk) begin : drive_elements
        logic           next_valid;
        gdtc_pkg::res_t predicted;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                predicted = tally_element(offered);
                results_due.insert(results_due.size(), predicted);
                accepted_count++;
                send_wait = draw_idle();
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (elements_queued.size() > 0) begin
                    offered = elements_queued.pop_front();
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
            s_tdata <= gdtc_pkg::S_TDATA_W'(offered.value);
            s_tlast <= offered.last;
        end
    end

    // Long receiver hold-off, started on request from the stimulus.
    always @(posedge aclk) begin : receiver_hold
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks every result word against the oldest prediction.
    always @(posedge aclk) begin : check_results
        gdtc_pkg::res_t got;
        gdtc_pkg::res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pairs_here = m_tdata[gdtc_pkg::PAIRS_OUT_W-1:0];
                got.triple_total = m_tdata[gdtc_pkg::PAIRS_OUT_W +: gdtc_pkg::TOTAL_W];
                got.overflow = m_tuser[0];
                got.last = m_tlast;
                results_seen++;
                if (got.overflow === 1'b1) begin
                    overflow_seen++;
                end
                if (got.triple_total > top_total) begin
                    top_total = got.triple_total;
                end
                if (results_due.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = results_due.pop_front();
                    if (got.pairs_here !== want.pairs_here
                            || got.triple_total !== want.triple_total
                            || got.overflow !== want.overflow
                            || got.last !== want.last) begin
                        note_mismatch("mismatch", want, got);
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_wait = draw_idle();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_element(input int v, input bit l);
        elem_t e;
        e.value = gdtc_pkg::VALUE_W'(v);
        e.last = l;
        elements_queued.insert(elements_queued.size(), e);
        queued_count++;
        seq_open = !l;
        if (l) begin
            sequences++;
        end
    endtask

    // Blocks until every word is accepted and answered, then lets the block settle.
    task automatic wait_idle();
        while (accepted_count != queued_count || results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_gap(input int g);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= gdtc_pkg::GAP_W'(g);
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        gap_setting = gdtc_pkg::GAP_W'(g);
        cfg_valid <= 1'b0;
        gaps_written++;
    endtask

    // One random sequence; its values are shaped so that the gap matters.
    task automatic queue_sequence(input int len, input bit close);
        spread_t spread;
        int      g;
        int      span;
        int      level;
        int      v;
        g = int'(gap_setting);
        if (g < 0) begin
            g = -g;
        end
        spread = spread_t'($urandom_range(0, 3));
        span = 3 * g + $urandom_range(4, 40);
        level = $urandom_range(0, RANGE - 1);
        for (int i = 0; i < len; i++) begin
            case (spread)
                SPREAD_UNIFORM: begin
                    v = $urandom_range(0, RANGE - 1);
                end
                SPREAD_WINDOW: begin
                    v = level + $urandom_range(0, span);
                end
                SPREAD_FALLING: begin
                    level = level - $urandom_range(0, 2 * g + 3);
                    if (level < 0 || $urandom_range(0, 15) == 0) begin
                        level = $urandom_range(RANGE / 2, RANGE - 1);
                    end
                    v = level;
                end
                default: begin
                    v = $urandom_range(0, 1) ? RANGE - 1 - $urandom_range(0, 3)
                                             : $urandom_range(0, 3);
                end
            endcase
            if (v > RANGE - 1) begin
                v = RANGE - 1;
            end
            queue_element(v, close && i == len - 1);
        end
    endtask

    function automatic int draw_gap_setting();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return 4095;
            4: return -4095;
            5, 6: return $urandom_range(0, 40) - 20;
            7, 8: return $urandom_range(0, 400) - 200;
            default: return $urandom_range(0, 8190) - 4095;
        endcase
    endfunction

    initial begin : stimulus
        int random_items;
        int nseq;
        int len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes and equal values at the reset gap of zero, a single-word sequence.
        queue_element(4095, 0);
        queue_element(4095, 0);
        queue_element(2048, 0);
        queue_element(0, 0);
        queue_element(0, 0);
        queue_element(4095, 1);
        queue_element(0, 1);
        // Largest gap: the threshold reaches the top of the value range or runs past it.
        write_gap(4095);
        queue_element(0, 0);
        queue_element(4095, 0);
        queue_element(0, 0);
        queue_element(0, 1);
        // Most negative gap: the threshold falls to zero or below, so all earlier words count.
        write_gap(-4095);
        queue_element(4095, 0);
        queue_element(0, 0);
        queue_element(2000, 0);
        queue_element(1, 1);
        // Small gaps: a falling run with repeats, then a rising run.
        write_gap(1);
        queue_element(100, 0);
        queue_element(99, 0);
        queue_element(99, 0);
        queue_element(98, 0);
        queue_element(50, 1);
        write_gap(-1);
        queue_element(5, 0);
        queue_element(6, 0);
        queue_element(7, 1);

        // Random phases: a new gap each phase, a sequence may stay open across a write.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            write_gap(draw_gap_setting());
            idle_mode = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) begin
                hold_requests++;
            end
            nseq = $urandom_range(1, 4);
            for (int s = 0; s < nseq; s++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 40);
                queue_sequence(len, !(s == nseq - 1 && $urandom_range(0, 3) == 0));
                random_items += len;
            end
        end
        if (seq_open) begin
            queue_element($urandom_range(0, RANGE - 1), 1);
        end

        // A long receiver hold while a full sequence is offered, so the input stalls.
        write_gap(0);
        idle_mode = 1;
        hold_requests++;
        queue_sequence(24, 1'b1);
        // The stores must start empty again after the previous sequence.
        queue_element(10, 0);
        queue_element(3, 0);
        queue_element(0, 1);

        wait_idle();
        $display("Ran %0d words in %0d sequences under %0d gap settings.",
                 accepted_count, sequences, gaps_written);
        $display("Compared %0d result words; %0d flagged overflow; top total %0d.",
                 results_seen, overflow_seen, top_total);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ gap_decreasing_triple_counter_unit.f @@
rtl/gdtc_pkg.sv
rtl/gdtc_tree_mem.sv
rtl/gdtc_ctrl.sv
rtl/gap_decreasing_triple_counter_unit.sv
dv/tb.sv
